// ===== hdl/progress_bar_column_generator_defines.svh =====
// Assertion macros for the progress bar column generator.
`ifndef PROGRESS_BAR_COLUMN_GENERATOR_DEFINES_SVH
`define PROGRESS_BAR_COLUMN_GENERATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PBCG_ASSERT_IMP(label, clock, rstn, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
`define PBCG_ASSERT_NXT(label, clock, rstn, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PBCG_ASSERT_IMP(label, clock, rstn, ante, cons, msg)
`define PBCG_ASSERT_NXT(label, clock, rstn, ante, cons, msg)
`endif

`endif

// ===== hdl/pbcg_pkg.sv =====
package pbcg_pkg;

	localparam int BAR_W  = 6;
	localparam int PCT_W  = 7;
	localparam int PROD_W = PCT_W + BAR_W;
	localparam int RECIP_W = 13;
	localparam int RECIP_SHIFT = 19;

	localparam logic [7:0] SOLID_BYTE   = 8'hFF;
	localparam logic [7:0] BORDER_TOP   = 8'h81;
	localparam logic [7:0] BORDER_PLAIN = 8'h80;
	localparam logic [PCT_W-1:0] FULL_PERCENT = 7'd100;
	localparam logic [BAR_W-1:0] MIN_BAR_WIDTH = 6'd2;

	// floor(x/100) == (x*5243)>>19 for every x up to 100*61
	localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

	localparam logic REG_INVERT_MASK = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_DIV,
		ST_EMPTY,
		ST_CLOSE
	} bar_state_t;

	typedef struct packed {
		logic [BAR_W-1:0] filled;
		logic [BAR_W-1:0] empty;
		logic [7:0]       pattern;
		logic [7:0]       border;
	} bar_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ===== hdl/pbcg_front.sv =====
module pbcg_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [7:0]                   percent,
	input  logic [5:0]                   bar_width,
	input  logic [7:0]                   fill_pattern,
	input  logic [2:0]                   text_row,
	input  pbcg_pkg::q_status_t          q_status,
	output logic                         q_push,
	output pbcg_pkg::bar_job_t           q_data
);

	logic                              valid_s1;
	logic [pbcg_pkg::PROD_W-1:0]       prod_s1;
	logic [pbcg_pkg::BAR_W-1:0]        inner_s1;
	logic [7:0]                        pattern_s1;
	logic [7:0]                        border_s1;

	logic                              accept;
	logic [pbcg_pkg::PCT_W-1:0]        pct;
	logic [pbcg_pkg::BAR_W-1:0]        width_c;
	logic [pbcg_pkg::BAR_W-1:0]        inner;
	logic [pbcg_pkg::PROD_W+pbcg_pkg::RECIP_W-1:0] scaled;
	logic [pbcg_pkg::BAR_W-1:0]        filled;

	assign in_stall = valid_s1 && q_status.full;
	assign accept   = in_valid && !in_stall;
	assign q_push   = valid_s1 && !q_status.full;

	always_comb begin
		pct = (percent > 8'(pbcg_pkg::FULL_PERCENT)) ? pbcg_pkg::FULL_PERCENT
			: percent[pbcg_pkg::PCT_W-1:0];
		// a 6-bit width cannot pass the 63 column limit
		width_c = (bar_width < pbcg_pkg::MIN_BAR_WIDTH) ? pbcg_pkg::MIN_BAR_WIDTH : bar_width;
		inner = width_c - pbcg_pkg::MIN_BAR_WIDTH;
	end

	always_comb begin
		scaled = (pbcg_pkg::PROD_W + pbcg_pkg::RECIP_W)'(prod_s1)
			* (pbcg_pkg::PROD_W + pbcg_pkg::RECIP_W)'(pbcg_pkg::RECIP_100);
		filled = scaled[pbcg_pkg::RECIP_SHIFT +: pbcg_pkg::BAR_W];
		q_data.filled  = filled;
		q_data.empty   = inner_s1 - filled;
		q_data.pattern = pattern_s1;
		q_data.border  = border_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || in_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prod_s1    <= pbcg_pkg::PROD_W'(pct) * pbcg_pkg::PROD_W'(inner);
			inner_s1   <= inner;
			pattern_s1 <= fill_pattern;
			border_s1  <= (text_row == 3'd0) ? pbcg_pkg::BORDER_TOP : pbcg_pkg::BORDER_PLAIN;
		end
	end

endmodule

// ===== hdl/pbcg_queue.sv =====
module pbcg_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  pbcg_pkg::bar_job_t  push_data,
	input  logic                pop,
	output pbcg_pkg::bar_job_t  pop_data,
	output pbcg_pkg::q_status_t status
);

	pbcg_pkg::bar_job_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign status.full  = (count_q == 2'd2);
	assign status.empty = (count_q == 2'd0);
	assign pop_data     = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== hdl/pbcg_back.sv =====
module pbcg_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          invert_mask,
	input  pbcg_pkg::q_status_t q_status,
	input  pbcg_pkg::bar_job_t  q_data,
	output logic                q_pop,
	output logic                busy,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          column_byte,
	output logic                last
);

	pbcg_pkg::bar_state_t        state_q, state_d;
	logic [pbcg_pkg::BAR_W-1:0]  cnt_q, cnt_d;
	logic [pbcg_pkg::BAR_W-1:0]  empty_q, empty_d;
	logic [7:0]                  pattern_q, pattern_d;
	logic [7:0]                  border_q, border_d;
	logic                        out_valid_q, out_valid_d;
	logic [7:0]                  byte_q, byte_d;
	logic                        last_q, last_d;
	logic                        advance;

	assign advance     = !out_valid_q || !out_stall;
	assign busy        = (state_q != pbcg_pkg::ST_IDLE);
	assign out_valid   = out_valid_q;
	assign column_byte = byte_q;
	assign last        = last_q;

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		empty_d     = empty_q;
		pattern_d   = pattern_q;
		border_d    = border_q;
		out_valid_d = out_valid_q;
		byte_d      = byte_q;
		last_d      = last_q;
		q_pop       = 1'b0;
		if (advance) begin
			out_valid_d = 1'b1;
			last_d      = 1'b0;
			case (state_q)
				pbcg_pkg::ST_IDLE: begin
					out_valid_d = !q_status.empty;
					byte_d      = pbcg_pkg::SOLID_BYTE ^ invert_mask;
					if (!q_status.empty) begin
						q_pop     = 1'b1;
						cnt_d     = q_data.filled;
						empty_d   = q_data.empty;
						pattern_d = q_data.pattern;
						border_d  = q_data.border;
						state_d   = (q_data.filled != '0) ? pbcg_pkg::ST_FILL : pbcg_pkg::ST_DIV;
					end
				end
				pbcg_pkg::ST_FILL: begin
					byte_d    = (pattern_q | border_q) ^ invert_mask;
					pattern_d = ~pattern_q;
					cnt_d     = cnt_q - pbcg_pkg::BAR_W'(1);
					if (cnt_q == 6'd1) state_d = pbcg_pkg::ST_DIV;
				end
				pbcg_pkg::ST_DIV: begin
					byte_d  = pbcg_pkg::SOLID_BYTE ^ invert_mask;
					cnt_d   = empty_q;
					state_d = (empty_q != '0) ? pbcg_pkg::ST_EMPTY : pbcg_pkg::ST_CLOSE;
				end
				pbcg_pkg::ST_EMPTY: begin
					byte_d = border_q ^ invert_mask;
					cnt_d  = cnt_q - pbcg_pkg::BAR_W'(1);
					if (cnt_q == 6'd1) state_d = pbcg_pkg::ST_CLOSE;
				end
				pbcg_pkg::ST_CLOSE: begin
					byte_d  = pbcg_pkg::SOLID_BYTE ^ invert_mask;
					last_d  = 1'b1;
					state_d = pbcg_pkg::ST_IDLE;
				end
				default: begin
					out_valid_d = 1'b0;
					state_d     = pbcg_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pbcg_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
			cnt_q       <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		empty_q   <= empty_d;
		pattern_q <= pattern_d;
		border_q  <= border_d;
		byte_q    <= byte_d;
		last_q    <= last_d;
	end

endmodule

// ===== hdl/progress_bar_column_generator.sv =====
// Progress bar column generator. Each accepted request (percent, bar_width, fill_pattern,
// text_row) produces max(bar_width,2)+1 column bytes, one per cycle while out_stall is low,
// with last set on the closing edge byte. Request parameters are registered, the filled
// count is formed by two multiplications, one on each side of that request register, and
// the request lands in a two-deep queue; the output sequencer then drains one request at a
// time, up to 64 bytes each, and an output stall holds the current byte. The first byte
// passes through the request register, the queue and the output byte register.
// invert_mask sits at APB byte address 0; write it only while no request is in flight.
`include "progress_bar_column_generator_defines.svh"

module progress_bar_column_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  percent,
	input  logic [5:0]  bar_width,
	input  logic [7:0]  fill_pattern,
	input  logic [2:0]  text_row,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  column_byte,
	output logic        last
);

	logic [7:0]          invert_mask_q;
	logic                q_push;
	logic                q_pop;
	logic                back_busy;
	pbcg_pkg::bar_job_t  push_data;
	pbcg_pkg::bar_job_t  pop_data;
	pbcg_pkg::q_status_t q_status;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == pbcg_pkg::REG_INVERT_MASK) ? {24'd0, invert_mask_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_mask_q <= 8'd0;
		end else if (psel && penable && pwrite && paddr[2] == pbcg_pkg::REG_INVERT_MASK) begin
			invert_mask_q <= pwdata[7:0];
		end
	end

	pbcg_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.percent      (percent),
		.bar_width    (bar_width),
		.fill_pattern (fill_pattern),
		.text_row     (text_row),
		.q_status     (q_status),
		.q_push       (q_push),
		.q_data       (push_data)
	);

	pbcg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.pop       (q_pop),
		.pop_data  (pop_data),
		.status    (q_status)
	);

	pbcg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.invert_mask (invert_mask_q),
		.q_status    (q_status),
		.q_data      (pop_data),
		.q_pop       (q_pop),
		.busy        (back_busy),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.column_byte (column_byte),
		.last        (last)
	);

	`PBCG_ASSERT_IMP(a_push_not_full, clk, arst_n, q_push, !q_status.full, "push into full queue")
	`PBCG_ASSERT_IMP(a_pop_not_empty, clk, arst_n, q_pop, !q_status.empty, "pop from empty queue")
	`PBCG_ASSERT_NXT(a_pop_starts_bar, clk, arst_n, q_pop, back_busy && out_valid, "pop without bar start")

endmodule
